>>> sv/qrs_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and request context type for the quadratic root solver
// no dependencies
package qrs_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int COEF_W = 16;
	localparam int DISC_W = 34;
	localparam int VAL_W = 48;

	localparam logic [1:0] SIGN_POS = 2'd0;
	localparam logic [1:0] SIGN_ZERO = 2'd1;
	localparam logic [1:0] SIGN_NEG = 2'd2;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_DISTINCT = 2'd1;
	localparam logic [1:0] KIND_EQUAL = 2'd2;
	localparam logic [1:0] KIND_COMPLEX = 2'd3;

	typedef struct packed {
		logic signed [COEF_W-1:0] a;
		logic signed [COEF_W-1:0] b;
		logic signed [DISC_W-1:0] disc;
		logic [1:0] sign;
		logic [1:0] kind;
	} qrs_ctx_t;

	// |2a| as a 17-bit magnitude
	function automatic logic [COEF_W:0] den_mag(input logic signed [COEF_W-1:0] a);
		logic [COEF_W-1:0] m;
		begin
			m = a[COEF_W-1] ? (~a + 1'b1) : a;
			den_mag = {m, 1'b0};
		end
	endfunction

endpackage

>>> sv/qrs_front.sv
`timescale 1ns / 1ps
// front end: products, exact discriminant, sign class and root kind
// depends on qrs_pkg
module qrs_front import qrs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     v_in,
	input  logic signed [COEF_W-1:0] a_in,
	input  logic signed [COEF_W-1:0] b_in,
	input  logic signed [COEF_W-1:0] c_in,
	output logic                     v_out,
	output qrs_ctx_t                 ctx_out,
	output logic [DISC_W-1:0]        mag_out
);

	logic                            v_s1;
	logic signed [2*COEF_W-1:0]      bb_s1;
	logic signed [2*COEF_W-1:0]      ac_s1;
	logic signed [COEF_W-1:0]        a_s1;
	logic signed [COEF_W-1:0]        b_s1;
	logic signed [DISC_W-1:0]        d;
	logic [1:0]                      sgn;
	logic [1:0]                      kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_out <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_out <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bb_s1 <= b_in * b_in;
			ac_s1 <= a_in * c_in;
			a_s1 <= a_in;
			b_s1 <= b_in;
		end
	end

	always_comb begin
		d = $signed({{(DISC_W-2*COEF_W){bb_s1[2*COEF_W-1]}}, bb_s1})
			- $signed({ac_s1, 2'b00});
		if (d[DISC_W-1])
			sgn = SIGN_NEG;
		else if (d == '0)
			sgn = SIGN_ZERO;
		else
			sgn = SIGN_POS;
		if (a_s1 == '0)
			kind = KIND_NONE;
		else if (sgn == SIGN_POS)
			kind = KIND_DISTINCT;
		else if (sgn == SIGN_ZERO)
			kind = KIND_EQUAL;
		else
			kind = KIND_COMPLEX;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_out.a <= a_s1;
			ctx_out.b <= b_s1;
			ctx_out.disc <= d;
			ctx_out.sign <= sgn;
			ctx_out.kind <= kind;
			mag_out <= d[DISC_W-1] ? DISC_W'(-d) : DISC_W'(d);
		end
	end

endmodule

>>> sv/qrs_sqrt_cell.sv
`timescale 1ns / 1ps
// one bit step of the scaled integer square root
// depends on qrs_pkg
module qrs_sqrt_cell import qrs_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int K = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   v_in,
	input  qrs_ctx_t               ctx_in,
	input  logic [DISC_W-1:0]      mag_in,
	input  logic [FRAC_BITS+18:0]  rem_in,
	input  logic [FRAC_BITS+16:0]  root_in,
	output logic                   v_q,
	output qrs_ctx_t               ctx_q,
	output logic [DISC_W-1:0]      mag_q,
	output logic [FRAC_BITS+18:0]  rem_q,
	output logic [FRAC_BITS+16:0]  root_q
);

	localparam int R = FRAC_BITS + 17;
	localparam int RW = R + 2;

	logic [1:0]      pair;
	logic [RW+1:0]   cur;
	logic [RW+1:0]   trial;
	logic            ge;

	generate
		if (K >= FRAC_BITS) begin : g_pair
			assign pair = mag_in[2*(K-FRAC_BITS) +: 2];
		end else begin : g_zero
			assign pair = 2'b00;
		end
	endgenerate

	always_comb begin
		cur = {rem_in, pair};
		trial = {2'b00, root_in, 2'b01};
		ge = cur >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else if (en)
			v_q <= v_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_q <= ctx_in;
			mag_q <= mag_in;
			rem_q <= ge ? RW'(cur - trial) : RW'(cur);
			root_q <= {root_in[R-2:0], ge};
		end
	end

endmodule

>>> sv/qrs_div_cell.sv
`timescale 1ns / 1ps
// one quotient bit step for both lanes of the restoring divider by |2a|
// depends on qrs_pkg
module qrs_div_cell import qrs_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int J = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         v_in,
	input  qrs_ctx_t                     ctx_in,
	input  logic [1:0][FRAC_BITS+17:0]   num_in,
	input  logic [1:0][COEF_W:0]         rem_in,
	input  logic [1:0][FRAC_BITS+17:0]   quo_in,
	input  logic [1:0]                   neg_in,
	output logic                         v_q,
	output qrs_ctx_t                     ctx_q,
	output logic [1:0][FRAC_BITS+17:0]   num_q,
	output logic [1:0][COEF_W:0]         rem_q,
	output logic [1:0][FRAC_BITS+17:0]   quo_q,
	output logic [1:0]                   neg_q
);

	localparam int NW = FRAC_BITS + 18;

	logic [COEF_W:0]          den;
	logic [1:0][COEF_W+1:0]   cur;
	logic [1:0]               ge;
	logic [1:0][COEF_W:0]     rem_n;

	always_comb begin
		den = den_mag(ctx_in.a);
		for (int l = 0; l < 2; l++) begin
			cur[l] = {rem_in[l], num_in[l][J]};
			ge[l] = cur[l] >= {1'b0, den};
			rem_n[l] = ge[l] ? (COEF_W+1)'(cur[l] - {1'b0, den}) : cur[l][COEF_W:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else if (en)
			v_q <= v_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_q <= ctx_in;
			num_q <= num_in;
			neg_q <= neg_in;
			rem_q <= rem_n;
			for (int l = 0; l < 2; l++)
				quo_q[l] <= {quo_in[l][NW-2:0], ge[l]};
		end
	end

endmodule

>>> sv/quadratic_root_solver_top.sv
`timescale 1ns / 1ps
// top level of the quadratic root solver: front end, square root and divider cell rows
// depends on qrs_pkg, qrs_front, qrs_sqrt_cell, qrs_div_cell
//
// Takes one coefficient set per cycle and returns the discriminant, its sign class,
// the root kind and two Q(47-FRAC_BITS).FRAC_BITS values (Q31.16 at FRAC_BITS = 16),
// through two front stages, one square root cell per root bit, one numerator stage,
// one divider cell per quotient bit and the output register. The whole row of cells
// moves whenever the output register is empty or being taken, so a new request enters
// every such cycle.
module quadratic_root_solver_top import qrs_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  logic signed [COEF_W-1:0] coef_a,
	input  logic signed [COEF_W-1:0] coef_b,
	input  logic signed [COEF_W-1:0] coef_c,
	output logic                     res_valid,
	input  logic                     res_ready,
	output logic signed [DISC_W-1:0] discriminant,
	output logic [1:0]               disc_sign,
	output logic [1:0]               root_kind,
	output logic signed [VAL_W-1:0]  first_value,
	output logic signed [VAL_W-1:0]  second_value
);

	localparam int R = FRAC_BITS + 17;
	localparam int RW = R + 2;
	localparam int NW = FRAC_BITS + 18;

	logic en;

	logic                 v_sq   [R+1];
	qrs_ctx_t             ctx_sq [R+1];
	logic [DISC_W-1:0]    mag_sq [R+1];
	logic [RW-1:0]        rem_sq [R+1];
	logic [R-1:0]         root_sq[R+1];

	logic                       v_dv   [NW+1];
	qrs_ctx_t                   ctx_dv [NW+1];
	logic [1:0][NW-1:0]         num_dv [NW+1];
	logic [1:0][COEF_W:0]       rem_dv [NW+1];
	logic [1:0][NW-1:0]         quo_dv [NW+1];
	logic [1:0]                 neg_dv [NW+1];

	logic signed [NW:0]   nb;
	logic signed [NW:0]   sv;
	logic signed [NW:0]   n1;
	logic signed [NW:0]   n2;

	logic [1:0][VAL_W-1:0] val;

	assign en = !res_valid || res_ready;
	assign req_ready = en;

	qrs_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (req_valid),
		.a_in    (coef_a),
		.b_in    (coef_b),
		.c_in    (coef_c),
		.v_out   (v_sq[0]),
		.ctx_out (ctx_sq[0]),
		.mag_out (mag_sq[0])
	);

	assign rem_sq[0] = '0;
	assign root_sq[0] = '0;

	generate
		for (genvar i = 0; i < R; i++) begin : g_sqrt
			qrs_sqrt_cell #(
				.FRAC_BITS (FRAC_BITS),
				.K         (R-1-i)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.v_in    (v_sq[i]),
				.ctx_in  (ctx_sq[i]),
				.mag_in  (mag_sq[i]),
				.rem_in  (rem_sq[i]),
				.root_in (root_sq[i]),
				.v_q     (v_sq[i+1]),
				.ctx_q   (ctx_sq[i+1]),
				.mag_q   (mag_sq[i+1]),
				.rem_q   (rem_sq[i+1]),
				.root_q  (root_sq[i+1])
			);
		end
	endgenerate

	// numerators by root kind
	always_comb begin
		nb = -($signed({{(NW+1-COEF_W){ctx_sq[R].b[COEF_W-1]}}, ctx_sq[R].b}) <<< FRAC_BITS);
		sv = $signed({{(NW+1-R){1'b0}}, root_sq[R]});
		case (ctx_sq[R].kind)
			KIND_DISTINCT: begin
				n1 = nb + sv;
				n2 = nb - sv;
			end
			KIND_EQUAL: begin
				n1 = nb;
				n2 = nb;
			end
			KIND_COMPLEX: begin
				n1 = nb;
				n2 = sv;
			end
			default: begin
				n1 = '0;
				n2 = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_dv[0] <= 1'b0;
		else if (en)
			v_dv[0] <= v_sq[R];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_dv[0] <= ctx_sq[R];
			num_dv[0][0] <= n1[NW] ? NW'(-n1) : n1[NW-1:0];
			num_dv[0][1] <= n2[NW] ? NW'(-n2) : n2[NW-1:0];
			neg_dv[0][0] <= n1[NW] ^ ctx_sq[R].a[COEF_W-1];
			neg_dv[0][1] <= n2[NW] ^ ctx_sq[R].a[COEF_W-1];
		end
	end

	assign rem_dv[0] = '0;
	assign quo_dv[0] = '0;

	generate
		for (genvar j = 0; j < NW; j++) begin : g_div
			qrs_div_cell #(
				.FRAC_BITS (FRAC_BITS),
				.J         (NW-1-j)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en),
				.v_in   (v_dv[j]),
				.ctx_in (ctx_dv[j]),
				.num_in (num_dv[j]),
				.rem_in (rem_dv[j]),
				.quo_in (quo_dv[j]),
				.neg_in (neg_dv[j]),
				.v_q    (v_dv[j+1]),
				.ctx_q  (ctx_dv[j+1]),
				.num_q  (num_dv[j+1]),
				.rem_q  (rem_dv[j+1]),
				.quo_q  (quo_dv[j+1]),
				.neg_q  (neg_dv[j+1])
			);
		end
	endgenerate

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			val[l] = {{(VAL_W-NW){1'b0}}, quo_dv[NW][l]};
			if (neg_dv[NW][l])
				val[l] = VAL_W'(-val[l]);
			if (ctx_dv[NW].kind == KIND_NONE)
				val[l] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid <= 1'b0;
		else if (en)
			res_valid <= v_dv[NW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			discriminant <= ctx_dv[NW].disc;
			disc_sign <= ctx_dv[NW].sign;
			root_kind <= ctx_dv[NW].kind;
			first_value <= val[0];
			second_value <= val[1];
		end
	end

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && root_kind == KIND_NONE |-> first_value == '0 && second_value == '0)
		else $error("values not cleared for a zero quadratic coefficient");

	a_sign_match: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((disc_sign == SIGN_NEG) == discriminant[DISC_W-1])
			&& ((disc_sign == SIGN_ZERO) == (discriminant == '0)))
		else $error("sign class disagrees with discriminant");

	a_equal_roots: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && root_kind == KIND_EQUAL |-> first_value == second_value)
		else $error("repeated root lanes differ");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(first_value) && $stable(second_value))
		else $error("result changed while stalled");

endmodule
